// File: sv/ccddb_pkg.sv
`default_nettype none

package ccddb_pkg;

  // Colour indices used by the reset value of a cell.
  localparam logic [3:0] COLOR_GRAY  = 4'd7;
  localparam logic [3:0] COLOR_BLACK = 4'd0;

  // One character cell: background, foreground and symbol.
  typedef struct packed {
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] symbol;
  } cell_t;

  localparam cell_t RESET_CELL = '{bg: COLOR_BLACK, fg: COLOR_GRAY, symbol: 8'd0};

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

endpackage

`default_nettype wire

// File: sv/char_cell_delta_display_buffer.sv
`default_nettype none

// Chan  Dir  Handshake                Payload
// in    in   in_valid_i/in_stall_o    op, row, col, symbol, fg_color, bg_color
// out   out  out_valid_o/out_stall_i  out_row, out_col, out_symbol, out_attribute, out_last
//
// After reset a sweep writes the reset cell into both stores, one address a cycle, and no
// input word is taken until the sweep has covered every address.
// A clear reads and rewrites every back cell.
// A row flush reads one column a cycle except while a stalled output holds it.
// Input words are taken only in the idle state; the output register lets a finished word
// wait while the next input word is accepted.
module char_cell_delta_display_buffer #(
  parameter int ROWS    = 32,
  parameter int COLUMNS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] row_i,
  input  wire logic [7:0] col_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic [3:0] fg_color_i,
  input  wire logic [3:0] bg_color_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_row_o,
  output logic [7:0]      out_col_o,
  output logic [7:0]      out_symbol_o,
  output logic [7:0]      out_attribute_o,
  output logic            out_last_o
);

  import ccddb_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = AW + 1;
  localparam int CCW   = $clog2(COLUMNS + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  sw_q, sw_d;
  logic [7:0]     row_q, row_d;
  logic [CCW-1:0] rd_col_q, rd_col_d;
  logic           cmp_v_q, cmp_v_d;
  logic [CCW-1:0] cmp_col_q, cmp_col_d;
  logic [AW-1:0]  cmp_addr_q, cmp_addr_d;
  logic           pend_v_q, pend_v_d;
  logic [CCW-1:0] pend_col_q, pend_col_d;
  cell_t          pend_cell_q, pend_cell_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_row_q, out_row_d;
  logic [7:0]     out_col_q, out_col_d;
  cell_t          out_cell_q, out_cell_d;
  logic           out_last_q, out_last_d;

  // Memory control.
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           back_we, shown_we;
  logic [AW-1:0]  back_waddr, shown_waddr;
  cell_t          back_wdata, shown_wdata;
  cell_t          back_rdata_q, shown_rdata_q;

  logic           out_free;
  logic           diff;
  logic           hold;
  logic           issue;
  logic           draw_ok;
  logic           flush_ok;
  logic [15:0]    draw_addr;
  logic [15:0]    scan_addr;

  // The two cell stores, each with one write and one registered read port.
  cell_t back_mem  [CELLS];
  cell_t shown_mem [CELLS];

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_waddr] <= back_wdata;
    end
    if (rd_en) begin
      back_rdata_q <= back_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shown_we) begin
      shown_mem[shown_waddr] <= shown_wdata;
    end
    if (rd_en) begin
      shown_rdata_q <= shown_mem[rd_addr];
    end
  end

  // Address and range decode.
  assign draw_addr = 16'(row_i) * 16'(COLUMNS) + 16'(col_i);
  assign scan_addr = 16'(row_q) * 16'(COLUMNS) + 16'(rd_col_q);
  assign draw_ok   = ({1'b0, row_i} < 9'(ROWS)) && ({1'b0, col_i} < 9'(COLUMNS));
  assign flush_ok  = {1'b0, row_i} < 9'(ROWS);

  // The output register can take a new word when empty or when its word leaves now.
  assign out_free = !out_valid_q || !out_stall_i;
  assign diff     = cmp_v_q && (back_rdata_q != shown_rdata_q);
  assign hold     = diff && pend_v_q && !out_free;
  assign issue    = rd_col_q < CCW'(COLUMNS);

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    sw_d        = sw_q;
    row_d       = row_q;
    rd_col_d    = rd_col_q;
    cmp_v_d     = cmp_v_q;
    cmp_col_d   = cmp_col_q;
    cmp_addr_d  = cmp_addr_q;
    pend_v_d    = pend_v_q;
    pend_col_d  = pend_col_q;
    pend_cell_d = pend_cell_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_cell_d  = out_cell_q;
    out_last_d  = out_last_q;
    rd_en       = 1'b0;
    rd_addr     = sw_q[AW-1:0];
    back_we     = 1'b0;
    back_waddr  = cmp_addr_q;
    back_wdata  = back_rdata_q;
    shown_we    = 1'b0;
    shown_waddr = cmp_addr_q;
    shown_wdata = back_rdata_q;

    unique case (state_q)
      ST_INIT: begin
        back_we     = 1'b1;
        shown_we    = 1'b1;
        back_waddr  = sw_q[AW-1:0];
        shown_waddr = sw_q[AW-1:0];
        back_wdata  = RESET_CELL;
        shown_wdata = RESET_CELL;
        sw_d        = sw_q + CW'(1);
        if (sw_q == CW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_DRAW: begin
              if (draw_ok) begin
                back_we    = 1'b1;
                back_waddr = AW'(draw_addr);
                back_wdata = '{bg: bg_color_i, fg: fg_color_i, symbol: symbol_i};
              end
            end
            OP_CLEAR: begin
              sw_d    = '0;
              cmp_v_d = 1'b0;
              state_d = ST_CLEAR;
            end
            OP_FLUSH: begin
              if (flush_ok) begin
                row_d    = row_i;
                rd_col_d = '0;
                cmp_v_d  = 1'b0;
                pend_v_d = 1'b0;
                state_d  = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Read each back cell and write it again with symbol and background cleared.
      ST_CLEAR: begin
        if (sw_q < CW'(CELLS)) begin
          rd_en = 1'b1;
          sw_d  = sw_q + CW'(1);
        end
        cmp_v_d    = sw_q < CW'(CELLS);
        cmp_addr_d = sw_q[AW-1:0];
        if (cmp_v_q) begin
          back_we    = 1'b1;
          back_wdata = '{bg: 4'd0, fg: back_rdata_q.fg, symbol: 8'd0};
        end
        if (!(sw_q < CW'(CELLS)) && !cmp_v_q) begin
          state_d = ST_IDLE;
        end
      end

      // One column a cycle unless a stalled output holds it; changed cells wait as pending
      // until the next one is found, so that the last word of the row can be marked.
      ST_SCAN: begin
        if (!hold) begin
          rd_en      = issue;
          rd_addr    = AW'(scan_addr);
          rd_col_d   = rd_col_q + CCW'(issue);
          cmp_v_d    = issue;
          cmp_col_d  = rd_col_q;
          cmp_addr_d = AW'(scan_addr);
          if (diff) begin
            shown_we = 1'b1;
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_row_d   = row_q;
              out_col_d   = 8'(pend_col_q);
              out_cell_d  = pend_cell_q;
              out_last_d  = 1'b0;
            end
            pend_v_d    = 1'b1;
            pend_col_d  = cmp_col_q;
            pend_cell_d = back_rdata_q;
          end
          if (!issue && !cmp_v_q) begin
            state_d = ST_DRAIN;
          end
        end
      end

      // Hand over the final changed cell, marked as last.
      ST_DRAIN: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_row_d   = row_q;
          out_col_d   = 8'(pend_col_q);
          out_cell_d  = pend_cell_q;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sw_q        <= '0;
      row_q       <= '0;
      rd_col_q    <= '0;
      cmp_v_q     <= 1'b0;
      cmp_col_q   <= '0;
      cmp_addr_q  <= '0;
      pend_v_q    <= 1'b0;
      pend_col_q  <= '0;
      pend_cell_q <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_cell_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      sw_q        <= sw_d;
      row_q       <= row_d;
      rd_col_q    <= rd_col_d;
      cmp_v_q     <= cmp_v_d;
      cmp_col_q   <= cmp_col_d;
      cmp_addr_q  <= cmp_addr_d;
      pend_v_q    <= pend_v_d;
      pend_col_q  <= pend_col_d;
      pend_cell_q <= pend_cell_d;
      out_valid_q <= out_valid_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_cell_q  <= out_cell_d;
      out_last_q  <= out_last_d;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign out_symbol_o    = out_cell_q.symbol;
  assign out_attribute_o = {out_cell_q.bg, out_cell_q.fg};
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire
